>>> rtl/core/gwg_pkg.sv
package gwg_pkg;

	// tuser codes of an input beat
	localparam logic FUNC_SEED = 1'b0;
	localparam logic FUNC_DRAW = 1'b1;

	// seeding recurrence
	localparam logic [31:0] SEED_MULT  = 32'd1812433253;
	localparam int unsigned SEED_SHIFT = 30;

	// regeneration mixing shifts
	localparam int unsigned FOLD_SHR  = 17;
	localparam int unsigned FOLD_SHL  = 22;
	localparam int unsigned MIX_SHL_A = 5;
	localparam int unsigned MIX_SHL_B = 9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_REGEN_RD,
		ST_REGEN_WR,
		ST_DRAW_RD,
		ST_DRAW_OUT
	} gwg_state_t;

	typedef struct packed {
		logic seed_start;   // load seed, write word 0
		logic seed_mul;     // multiply step of the recurrence
		logic seed_add;     // add index, write word or carry
		logic regen_start;  // rewind regeneration pointers
		logic regen_rd;     // read word i and its far partner
		logic regen_wr;     // mix and write word i
		logic draw_rd;      // read word at read position
		logic draw_out;     // load output register, advance position
	} gwg_cmd_t;

	typedef struct packed {
		logic seed_last;    // seed counter reached the carried word
		logic regen_last;   // regeneration at the last word
		logic pos_end;      // read position past the store
		logic out_free;     // output register can take a word
	} gwg_status_t;

endpackage

>>> rtl/core/gwg_ctrl.sv
module gwg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                func,
	input  gwg_pkg::gwg_status_t status,
	output gwg_pkg::gwg_cmd_t    cmd
);
	import gwg_pkg::*;

	gwg_state_t state_q;
	gwg_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (func == FUNC_SEED) begin
						state_nxt = ST_SEED_MUL;
					end else if (status.pos_end) begin
						state_nxt = ST_REGEN_RD;
					end else begin
						state_nxt = ST_DRAW_RD;
					end
				end
			end
			ST_SEED_MUL: state_nxt = ST_SEED_ADD;
			ST_SEED_ADD: begin
				state_nxt = status.seed_last ? ST_IDLE : ST_SEED_MUL;
			end
			ST_REGEN_RD: state_nxt = ST_REGEN_WR;
			ST_REGEN_WR: begin
				state_nxt = status.regen_last ? ST_DRAW_RD : ST_REGEN_RD;
			end
			ST_DRAW_RD: state_nxt = ST_DRAW_OUT;
			ST_DRAW_OUT: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready        = 1'b1;
				cmd.seed_start  = s_tvalid && (func == FUNC_SEED);
				cmd.regen_start = s_tvalid && (func == FUNC_DRAW) && status.pos_end;
			end
			ST_SEED_MUL: cmd.seed_mul = 1'b1;
			ST_SEED_ADD: cmd.seed_add = 1'b1;
			ST_REGEN_RD: cmd.regen_rd = 1'b1;
			ST_REGEN_WR: cmd.regen_wr = 1'b1;
			ST_DRAW_RD:  cmd.draw_rd  = 1'b1;
			ST_DRAW_OUT: cmd.draw_out = status.out_free;
			default: begin
				cmd      = '0;
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/core/gwg_dp.sv
module gwg_dp #(
	parameter int STATE_WORDS = 623,
	parameter int MID_OFFSET  = 294
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gwg_pkg::gwg_cmd_t     cmd,
	output gwg_pkg::gwg_status_t  status,
	input  logic [31:0]          seed,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata
);
	import gwg_pkg::*;

	localparam int AW = $clog2(STATE_WORDS);
	localparam int CW = $clog2(STATE_WORDS + 1);
	localparam logic [CW-1:0] END_CNT  = CW'(STATE_WORDS);
	localparam logic [AW-1:0] LAST_IDX = AW'(STATE_WORDS - 1);
	localparam logic [AW-1:0] MID_IDX  = AW'(MID_OFFSET);

	logic [31:0] mem [STATE_WORDS];

	logic [AW-1:0] idx_q;
	logic [AW-1:0] far_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic [31:0]   carry_q;
	logic [31:0]   prev_q;
	logic [31:0]   product_q;
	logic [31:0]   rd_a_q;
	logic [31:0]   rd_b_q;
	logic          out_valid_q;
	logic [31:0]   out_data_q;

	logic [31:0]   seed_mix;
	logic [31:0]   seed_next;
	logic [31:0]   u_fold;
	logic [31:0]   u_far;
	logic [31:0]   u_mix;
	logic [31:0]   regen_word;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_a_addr;

	// seeding recurrence, split into a registered multiply step and an add step
	assign seed_mix  = prev_q ^ (prev_q >> SEED_SHIFT);
	assign seed_next = product_q + 32'(cnt_q);

	// one regeneration step; carry_q holds the running mix word
	assign u_fold     = carry_q ^ (rd_a_q >> FOLD_SHR) ^ (rd_a_q << FOLD_SHL);
	assign u_far      = u_fold ^ rd_b_q;
	assign u_mix      = u_far ^ (u_far << MIX_SHL_A);
	assign regen_word = rd_a_q ^ u_mix ^ (u_mix << MIX_SHL_B);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = regen_word;
		if (cmd.seed_start) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = seed;
		end else if (cmd.seed_add) begin
			wr_en   = (cnt_q != END_CNT);
			wr_addr = cnt_q[AW-1:0];
			wr_data = seed_next;
		end else if (cmd.regen_wr) begin
			wr_en = 1'b1;
		end
	end

	assign rd_en     = cmd.regen_rd | cmd.draw_rd;
	assign rd_a_addr = cmd.draw_rd ? pos_q[AW-1:0] : idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[far_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_start) begin
			prev_q <= seed;
		end else if (cmd.seed_add) begin
			prev_q <= seed_next;
		end
		if (cmd.seed_mul) begin
			product_q <= SEED_MULT * seed_mix;
		end
		if (cmd.draw_out) begin
			out_data_q <= rd_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			far_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= END_CNT;
			carry_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_start) begin
				cnt_q <= CW'(1);
				pos_q <= END_CNT;
			end
			if (cmd.seed_add) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == END_CNT) begin
					carry_q <= seed_next;
				end
			end
			if (cmd.regen_start) begin
				idx_q <= '0;
				far_q <= MID_IDX;
			end
			if (cmd.regen_wr) begin
				carry_q <= u_mix;
				idx_q   <= idx_q + AW'(1);
				far_q   <= (far_q == LAST_IDX) ? '0 : far_q + AW'(1);
				if (idx_q == LAST_IDX) begin
					pos_q <= '0;
				end
			end
			if (cmd.draw_out) begin
				pos_q <= pos_q + CW'(1);
			end
			if (cmd.draw_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.seed_last  = (cnt_q == END_CNT);
	assign status.regen_last = (idx_q == LAST_IDX);
	assign status.pos_end    = (pos_q >= END_CNT);
	assign status.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_regen_rewinds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.regen_wr && status.regen_last |=> pos_q == '0)
		else $error("read position not rewound after regeneration");

	a_regen_start_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.regen_start |=> (idx_q == '0) && (far_q == MID_IDX))
		else $error("regeneration pointers not initialized");

	a_draw_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_rd |-> !status.pos_end)
		else $error("draw read beyond the store");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_out |-> status.out_free)
		else $error("output register overwritten while held");

endmodule

>>> rtl/core/gfsr_word_generator.sv
// Draw: reads the store (ST_DRAW_RD), then loads the output register (ST_DRAW_OUT), which
//   waits while m_tvalid is held; a draw that finds the store used up first regenerates it.
// Flow: one beat in flight; a seed runs a multiply/add step per word and a regeneration runs
//   a read/write step per word on the store.
// Reset (arst_n low): control idle, carry word zero, read position at the end of the store;
//   the store itself is not cleared and reads undefined until the first seed.
module gfsr_word_generator #(
	parameter int STATE_WORDS = 623,  // words in the store
	parameter int MID_OFFSET  = 294   // distance to the far word, 1 .. STATE_WORDS-1
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] seed
	input  logic [0:0]  s_tuser,   // [0] func: 0 seed, 1 draw
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] random_word
);
	import gwg_pkg::*;

	gwg_cmd_t    cmd;
	gwg_status_t status;

	// Controller: sequences seeding (multiply, add per word), regeneration
	// (read pair, mix and write per word) and the draw read.
	gwg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser[0]),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: word store with one write and two registered read ports,
	// seed multiplier, mixing logic, pointers and the output register.
	gwg_dp #(
		.STATE_WORDS (STATE_WORDS),
		.MID_OFFSET  (MID_OFFSET)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.seed     (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> tb/tb_gfsr_word_generator.sv
`timescale 1ns / 1ps

module tb_gfsr_word_generator;
	import gwg_pkg::*;

	localparam int STATE_WORDS = 623;
	localparam int MID_OFFSET  = 294;
	localparam int ITEM_BUDGET = 2000;
	localparam int IDLE_PCT    = 14;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] seed
	logic [0:0]  s_tuser = FUNC_SEED;   // [0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;   // [31:0] random_word

	// predictor state
	logic [31:0] words [STATE_WORDS];
	int unsigned word_pos;
	logic [31:0] carry;

	logic [31:0] pending_words [$];
	int unsigned beats_sent;
	int unsigned mismatches;
	bit          steady;   // no idling on either side while set

	gfsr_word_generator #(
		.STATE_WORDS(STATE_WORDS),
		.MID_OFFSET (MID_OFFSET)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// multiplicative fill; the word past the store becomes the carry
	function automatic void seed_words(input logic [31:0] seed);
		logic [31:0] prev;
		logic [31:0] nxt;
		prev = seed;
		words[0] = seed;
		for (int k = 1; k <= STATE_WORDS; k++) begin
			nxt = SEED_MULT * (prev ^ (prev >> SEED_SHIFT)) + k;
			if (k < STATE_WORDS)
				words[k] = nxt;
			else
				carry = nxt;
			prev = nxt;
		end
		word_pos = STATE_WORDS;
	endfunction

	// in-place refill; far words past the wrap are already refreshed
	function automatic void refill_words();
		logic [31:0] u;
		logic [31:0] w;
		logic [31:0] far;
		u = carry;
		for (int i = 0; i < STATE_WORDS; i++) begin
			w = words[i];
			far = words[(i + MID_OFFSET) % STATE_WORDS];
			u ^= (w >> FOLD_SHR) ^ (w << FOLD_SHL);
			u ^= far;
			u ^= u << MIX_SHL_A;
			words[i] = w ^ u ^ (u << MIX_SHL_B);
		end
		carry = u;
		word_pos = 0;
	endfunction

	function automatic logic [31:0] draw_word();
		logic [31:0] w;
		if (word_pos >= STATE_WORDS)
			refill_words();
		w = words[word_pos];
		word_pos++;
		return w;
	endfunction

	// one input beat; valid stays high into the next call unless it idles
	task automatic send_beat(input logic func, input logic [31:0] seed);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= seed;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
		if (func == FUNC_SEED)
			seed_words(seed);
		else
			pending_words.push_back(draw_word());
	endtask

	task automatic seed_beat(input logic [31:0] seed);
		send_beat(FUNC_SEED, seed);
	endtask

	task automatic draw_beats(input int unsigned n);
		for (int unsigned j = 0; j < n; j++)
			send_beat(FUNC_DRAW, $urandom());
	endtask

	// hold input until every word is back, then let a trailing seed finish
	task automatic drain();
		if (beats_sent != 0) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (2 * STATE_WORDS + 16) @(posedge clk);
	endtask

	// result side: sample pre-edge handshake, then pick next ready
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_words.size() == 0) begin
					$error("random_word: expected none, actual %h", m_tdata);
					mismatches++;
				end else begin
					logic [31:0] want;
					want = pending_words.pop_front();
					if (m_tdata !== want) begin
						$error("random_word: expected %h, actual %h", want, m_tdata);
						mismatches++;
					end
				end
			end
			m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic reset_dut();
		word_pos = STATE_WORDS;
		carry = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// extreme seeds, reseeding mid-stream and back to back, odd seed fields on draws
	task automatic test_directed();
		seed_beat(32'h0000_0000);
		draw_beats(3);
		seed_beat(32'hFFFF_FFFF);
		draw_beats(3);
		seed_beat(32'h0000_0001);
		send_beat(FUNC_DRAW, 32'hFFFF_FFFF);
		send_beat(FUNC_DRAW, 32'h0000_0000);
		seed_beat(32'h8000_0000);
		seed_beat(32'h7FFF_FFFF);
		draw_beats(2);
		seed_beat(32'd19937);
		draw_beats(2);
	endtask

	// long stretch with no idling that crosses a refill boundary
	task automatic test_back_to_back();
		steady = 1'b1;
		seed_beat($urandom());
		draw_beats($urandom_range(STATE_WORDS + 20, STATE_WORDS + 200));
		steady = 1'b0;
	endtask

	// seed then a run of draws; a quarter of runs last one to just over two store lengths,
	// the last run is cut to the item budget
	task automatic test_random_runs();
		int unsigned run;
		while (beats_sent < ITEM_BUDGET) begin
			seed_beat($urandom());
			if ($urandom_range(0, 3) == 0)
				run = $urandom_range(STATE_WORDS, 2 * STATE_WORDS + 50);
			else
				run = $urandom_range(20, 80);
			if (run > ITEM_BUDGET - beats_sent)
				run = ITEM_BUDGET - beats_sent;
			draw_beats(run);
		end
	endtask

	initial begin
		beats_sent = 0;
		mismatches = 0;
		steady = 1'b0;
		reset_dut();
		test_directed();
		drain();
		test_back_to_back();
		test_random_runs();
		drain();
		if (mismatches == 0)
			$display("** gfsr_word_generator: PASSED **");
		else
			$display("** gfsr_word_generator: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** gfsr_word_generator: FAILED **");
		$finish;
	end

endmodule
